// ===== hw/rtl/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere generator package
// Shared types, fixed-point constants and arithmetic helpers for the UV sphere
// tessellation core and its request channel interface.
// ----------------------------------------------------------------------------
package uvs_pkg;

   // Request function codes.
   typedef enum logic {
      FUNC_VERTEX = 1'b0,
      FUNC_QUAD   = 1'b1
   } func_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_SLICES = 2'd1;
   localparam logic [1:0] CSR_STACKS = 2'd2;

   // Largest usable division count around or along the sphere.
   localparam logic [7:0] MAX_DIVISIONS = 8'd255;

   // Divider geometry: 24-bit numerator, two quotient bits per stage.
   localparam int unsigned DIV_W              = 24;
   localparam int unsigned DIV_BITS_PER_STAGE = 2;
   localparam int unsigned DIV_STAGES         = DIV_W / DIV_BITS_PER_STAGE;

   // CORDIC datapath width and constants in Q2.30; unit-range bounds in Q1.14.
   localparam int unsigned CW           = 34;
   localparam int unsigned ATAN_ENTRIES = 24;
   localparam logic [31:0] PI_Q30       = 32'd3373259426;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CW-1:0] UNIT_HI     = 34'sd16384;
   localparam logic signed [CW-1:0] UNIT_LO     = -34'sd16384;

   localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   // Partial state of the restoring divider: remainder and shifting numerator,
   // whose low bits fill up with quotient bits.
   typedef struct packed {
      logic [7:0]       rem;
      logic [DIV_W-1:0] num;
   } div_type;

   // Cosine and sine pair in Q1.14.
   typedef struct packed {
      logic signed [15:0] c;
      logic signed [15:0] s;
   } trig_type;

   // Fields that travel alongside the arithmetic through the pipeline.
   typedef struct packed {
      func_type    func;
      logic [15:0] idx_a;
      logic [15:0] idx_b;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [1:0]  quad_t;
      logic [1:0]  quad_p;
   } side_type;

   // Two restoring division steps against an 8-bit divisor.
   function automatic div_type div_step(div_type cur, logic [7:0] d);
      div_type    nxt;
      logic [8:0] trial;
      nxt = cur;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         trial   = {nxt.rem, nxt.num[DIV_W-1]};
         nxt.num = {nxt.num[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            nxt.rem    = 8'(trial - {1'b0, d});
            nxt.num[0] = 1'b1;
         end else begin
            nxt.rem = trial[7:0];
         end
      end
      return nxt;
   endfunction

   // Round a Q2.30 value to Q1.14 and clamp it to the unit range.
   function automatic logic signed [15:0] round_unit(logic signed [CW-1:0] v);
      logic signed [CW-1:0] r;
      r = (v + 34'sd32768) >>> 16;
      if (r > UNIT_HI) begin
         r = UNIT_HI;
      end else if (r < UNIT_LO) begin
         r = UNIT_LO;
      end
      return 16'(r);
   endfunction

   // Apply the quadrant of the turn to a first-quadrant cosine and sine.
   function automatic trig_type quad_map(logic [1:0] q, logic signed [15:0] c,
                                         logic signed [15:0] s);
      trig_type t;
      case (q)
         2'd0:    begin t.c = c;  t.s = s;  end
         2'd1:    begin t.c = -s; t.s = c;  end
         2'd2:    begin t.c = -c; t.s = -s; end
         default: begin t.c = s;  t.s = -c; end
      endcase
      return t;
   endfunction

endpackage

// ===== hw/rtl/uvs_req_if.sv =====
// ----------------------------------------------------------------------------
// UV sphere request channel
// Valid/ready channel carrying one request word: function, column and row.
// ----------------------------------------------------------------------------
interface uvs_req_if;
   import uvs_pkg::*;

   logic       valid;
   logic       ready;
   func_type   func;
   logic [7:0] column;
   logic [7:0] row;

   modport source (output valid, func, column, row, input ready);
   modport sink   (input valid, func, column, row, output ready);
endinterface

// ===== hw/rtl/uvs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// UV sphere result channel
// Valid/ready channel carrying one result word: vertex data or triangle indices.
// ----------------------------------------------------------------------------
interface uvs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] pos_x;
   logic signed [16:0] pos_y;
   logic signed [16:0] pos_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [16:0]        tex_u;
   logic [16:0]        tex_v;
   logic [15:0]        corner_a;
   logic [15:0]        corner_b;
   logic [15:0]        corner_c;
   logic               last;

   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                   corner_a, corner_b, corner_c, last, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                   corner_a, corner_b, corner_c, last, output ready);
endinterface

// ===== hw/rtl/uv_sphere_mesh_generator_core.sv =====
// ----------------------------------------------------------------------------
// UV sphere tessellation core
// Produces sphere vertices (position, normal, texture coordinates) and quad
// triangle indices from column/row requests.
// ----------------------------------------------------------------------------
// Usage:
//  - req carries one request word (func, column, row). A vertex request yields
//    one result word; a quad request yields two words, the second with last.
//  - rsp carries result words; last marks the final word of each request.
//  - csr_we/csr_index/csr_wdata write radius, slice count and stack count.
//    Write them only while no request is in flight.
//  - From request to first result word the pipeline has one input stage,
//    twelve divider stages (two quotient bits each), an angle stage, one
//    CORDIC stage per iteration (TRIG_STAGES of them), then rounding,
//    normal and position stages.
//  - One request is accepted every cycle while results drain; a quad request
//    holds the pipeline while its second word goes out.
//  - When rsp is stalled, the whole pipeline holds and req.ready drops;
//    nothing is lost or repeated.
//  - Reset clears the pipeline and loads radius 1.0, 16 slices, 16 stacks.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator_core #(
   parameter int unsigned TRIG_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   uvs_req_if.sink     req,
   uvs_rsp_if.source   rsp
);
   import uvs_pkg::*;

   localparam int unsigned ZS = DIV_STAGES + 1;
   localparam int unsigned RC = ZS + TRIG_STAGES + 1;
   localparam int unsigned NS = RC + 1;
   localparam int unsigned PS = NS + 1;

   logic [15:0] radius_ff;
   logic [7:0]  slices_ff;
   logic [7:0]  stacks_ff;
   logic [7:0]  s_eff;
   logic [7:0]  t_eff;
   logic        adv;
   logic        beat_ff;

   logic       vld_ff  [0:PS];
   side_type   side_ff [0:PS];
   side_type   side0;
   div_type    div_ff  [0:2][0:DIV_STAGES];
   logic signed [CW-1:0] cx_ff [0:1][1:TRIG_STAGES];
   logic signed [CW-1:0] cy_ff [0:1][1:TRIG_STAGES];
   logic signed [CW-1:0] cz_ff [0:1][0:TRIG_STAGES-1];
   trig_type   trig_ff [0:1];
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [15:0] onx_ff, ony_ff, onz_ff;
   logic signed [16:0] px_ff, py_ff, pz_ff;

   logic [7:0]  col_v, row_v, col_q, row_q;
   logic [8:0]  stride;
   logic [16:0] a_full;
   logic [16:0] b_full;
   logic [DIV_W-1:0] num_u, num_v, num_p;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         slices_ff <= 8'd16;
         stacks_ff <= 8'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata;
            CSR_SLICES: slices_ff <= csr_wdata[7:0];
            CSR_STACKS: stacks_ff <= csr_wdata[7:0];
            default:    ;
         endcase
      end
   end

   // Effective division counts: zero acts as one, large values saturate.
   always_comb begin
      s_eff = slices_ff;
      t_eff = stacks_ff;
      if (s_eff == 8'd0) s_eff = 8'd1;
      if (s_eff > MAX_DIVISIONS) s_eff = MAX_DIVISIONS;
      if (t_eff == 8'd0) t_eff = 8'd1;
      if (t_eff > MAX_DIVISIONS) t_eff = MAX_DIVISIONS;
   end

   // The pipeline moves whenever the output word is empty or fully delivered.
   assign adv = !vld_ff[PS] ||
                (rsp.ready && (side_ff[PS].func == FUNC_VERTEX || beat_ff));
   assign req.ready = adv;

   // Input clamping, quad indices and divider numerators.
   always_comb begin
      col_v  = (req.column > s_eff) ? s_eff : req.column;
      row_v  = (req.row > t_eff) ? t_eff : req.row;
      col_q  = (req.column > 8'(s_eff - 8'd1)) ? 8'(s_eff - 8'd1) : req.column;
      row_q  = (req.row > 8'(t_eff - 8'd1)) ? 8'(t_eff - 8'd1) : req.row;
      stride = {1'b0, s_eff} + 9'd1;
      a_full = 17'(row_q) * 17'(stride) + 17'(col_q);
      b_full = a_full + 17'(stride);
      num_u  = {col_v, 16'd0} + 24'(s_eff >> 1);
      num_v  = {row_v, 16'd0} + 24'(t_eff >> 1);
      num_p  = {1'b0, row_v, 15'd0} + 24'(t_eff >> 1);
      side0        = '0;
      side0.func   = req.func;
      side0.idx_a  = a_full[15:0];
      side0.idx_b  = b_full[15:0];
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= PS; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req.valid;
         for (int k = 1; k <= PS; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // Second word of a quad request.
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= 1'b0;
      end else if (adv) begin
         beat_ff <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         beat_ff <= 1'b1;
      end
   end

   // Input stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0]   <= side0;
         div_ff[0][0] <= '{rem: 8'd0, num: num_u};
         div_ff[1][0] <= '{rem: 8'd0, num: num_v};
         div_ff[2][0] <= '{rem: 8'd0, num: num_p};
      end
   end

   // Divider stages for the column fraction, row fraction and polar turn.
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[0][k] <= div_step(div_ff[0][k-1], s_eff);
            div_ff[1][k] <= div_step(div_ff[1][k-1], t_eff);
            div_ff[2][k] <= div_step(div_ff[2][k-1], t_eff);
            side_ff[k]   <= side_ff[k-1];
         end
      end
   end

   // Angle stage: texture coordinates, quadrants and radians in Q2.30.
   logic [16:0] uf, vf;
   logic [15:0] ph;
   logic [45:0] zp_t, zp_p;
   side_type    side_z;

   always_comb begin
      uf     = div_ff[0][DIV_STAGES].num[16:0];
      vf     = div_ff[1][DIV_STAGES].num[16:0];
      ph     = div_ff[2][DIV_STAGES].num[15:0];
      zp_t   = 46'(uf[13:0]) * 46'(PI_Q30);
      zp_p   = 46'(ph[13:0]) * 46'(PI_Q30);
      side_z        = side_ff[DIV_STAGES];
      side_z.tex_u  = 17'(17'd65536 - uf);
      side_z.tex_v  = vf;
      side_z.quad_t = uf[15:14];
      side_z.quad_p = ph[15:14];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[ZS] <= side_z;
         cz_ff[0][0] <= $signed({3'b000, zp_t[45:15]});
         cz_ff[1][0] <= $signed({3'b000, zp_p[45:15]});
      end
   end

   // CORDIC rotation stages, one iteration per stage for each angle.
   for (genvar i = 1; i <= TRIG_STAGES; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv) side_ff[ZS+i] <= side_ff[ZS+i-1];
      end
      for (genvar u = 0; u < 2; u++) begin : g_unit
         logic signed [CW-1:0] xp, yp, xs, ys;
         logic                 neg;
         if (i == 1) begin : g_first
            assign xp = CORDIC_GAIN;
            assign yp = '0;
         end else begin : g_next
            assign xp = cx_ff[u][i-1];
            assign yp = cy_ff[u][i-1];
         end
         assign xs  = xp >>> (i - 1);
         assign ys  = yp >>> (i - 1);
         assign neg = cz_ff[u][i-1][CW-1];
         always_ff @(posedge clock) begin
            if (adv) begin
               cx_ff[u][i] <= neg ? xp + ys : xp - ys;
               cy_ff[u][i] <= neg ? yp - xs : yp + xs;
            end
         end
         if (i < TRIG_STAGES) begin : g_z
            always_ff @(posedge clock) begin
               if (adv) begin
                  cz_ff[u][i] <= neg ? cz_ff[u][i-1] + $signed({2'b00, ATAN_Q30[i-1]})
                                     : cz_ff[u][i-1] - $signed({2'b00, ATAN_Q30[i-1]});
               end
            end
         end
      end
   end

   // Rounding, clamping and quadrant mapping.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[RC] <= side_ff[RC-1];
         trig_ff[0]  <= quad_map(side_ff[RC-1].quad_t,
                                 round_unit(cx_ff[0][TRIG_STAGES]),
                                 round_unit(cy_ff[0][TRIG_STAGES]));
         trig_ff[1]  <= quad_map(side_ff[RC-1].quad_p,
                                 round_unit(cx_ff[1][TRIG_STAGES]),
                                 round_unit(cy_ff[1][TRIG_STAGES]));
      end
   end

   // Normal stage.
   logic signed [31:0] prod_x, prod_z;
   always_comb begin
      prod_x = trig_ff[0].c * trig_ff[1].s + 32'sd8192;
      prod_z = trig_ff[0].s * trig_ff[1].s + 32'sd8192;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[NS] <= side_ff[RC];
         nx_ff       <= 16'(prod_x >>> 14);
         ny_ff       <= trig_ff[1].c;
         nz_ff       <= 16'(prod_z >>> 14);
      end
   end

   // Position stage, which is also the output register.
   logic signed [32:0] pos_px, pos_py, pos_pz;
   always_comb begin
      pos_px = $signed({1'b0, radius_ff}) * nx_ff + 33'sd8192;
      pos_py = $signed({1'b0, radius_ff}) * ny_ff + 33'sd8192;
      pos_pz = $signed({1'b0, radius_ff}) * nz_ff + 33'sd8192;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[PS] <= side_ff[NS];
         onx_ff      <= nx_ff;
         ony_ff      <= ny_ff;
         onz_ff      <= nz_ff;
         px_ff       <= 17'(pos_px >>> 14);
         py_ff       <= 17'(pos_py >>> 14);
         pz_ff       <= 17'(pos_pz >>> 14);
      end
   end

   // Result word: vertex data, or one of the two triangles of a quad.
   always_comb begin
      rsp.valid    = vld_ff[PS];
      rsp.pos_x    = '0;
      rsp.pos_y    = '0;
      rsp.pos_z    = '0;
      rsp.norm_x   = '0;
      rsp.norm_y   = '0;
      rsp.norm_z   = '0;
      rsp.tex_u    = '0;
      rsp.tex_v    = '0;
      rsp.corner_a = '0;
      rsp.corner_b = '0;
      rsp.corner_c = '0;
      rsp.last     = 1'b1;
      if (side_ff[PS].func == FUNC_VERTEX) begin
         rsp.pos_x  = px_ff;
         rsp.pos_y  = py_ff;
         rsp.pos_z  = pz_ff;
         rsp.norm_x = onx_ff;
         rsp.norm_y = ony_ff;
         rsp.norm_z = onz_ff;
         rsp.tex_u  = side_ff[PS].tex_u;
         rsp.tex_v  = side_ff[PS].tex_v;
      end else if (!beat_ff) begin
         rsp.corner_a = side_ff[PS].idx_a;
         rsp.corner_b = 16'(side_ff[PS].idx_a + 16'd1);
         rsp.corner_c = side_ff[PS].idx_b;
         rsp.last     = 1'b0;
      end else begin
         rsp.corner_a = side_ff[PS].idx_b;
         rsp.corner_b = 16'(side_ff[PS].idx_a + 16'd1);
         rsp.corner_c = 16'(side_ff[PS].idx_b + 16'd1);
      end
   end

`ifndef SYNTHESIS
   // The second-word flag is only set while a quad result is held.
   a_beat_quad: assert property (@(posedge clock) disable iff (reset)
      beat_ff |-> (vld_ff[PS] && side_ff[PS].func == FUNC_QUAD))
      else $error("second word flag set without a quad result");

   // Requests are only held back by a waiting result word.
   a_ready_hold: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("request side stalled with no result waiting");

   // The first word of a quad is always followed by its final word.
   a_quad_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last) |=> (rsp.valid && rsp.last))
      else $error("quad second word missing");

   // Vertex results are single words.
   a_vertex_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && side_ff[PS].func == FUNC_VERTEX) |-> rsp.last)
      else $error("vertex result without last");
`endif

endmodule
